// ----- design/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared widths, status codes and check matrix builders for the systematic
// Hamming single-error-correcting codec.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

    localparam int DataW   = 32;
    localparam int CheckW  = 6;
    localparam int PosW    = 5;
    localparam int StatusW = 2;
    localparam int MaxCols = 64;
    localparam int IdxW    = 6;
    localparam int SyndCount = 64;

    localparam logic [StatusW-1:0] StatusNone      = 2'd0;
    localparam logic [StatusW-1:0] StatusCorrected = 2'd1;
    localparam logic [StatusW-1:0] StatusUnmatched = 2'd2;

    typedef logic [MaxCols-1:0][CheckW-1:0] col_table_t;

    typedef struct packed {
        logic            hit;
        logic [IdxW-1:0] idx;
    } lookup_entry_t;

    typedef lookup_entry_t [SyndCount-1:0] lookup_table_t;

    // Columns are all values of weight two in ascending order, then weight
    // three, and so on; unfilled columns stay zero.
    function automatic col_table_t build_columns(input int check_bits);
        col_table_t cols;
        int         filled;
        cols   = '0;
        filled = 0;
        for (int w = 2; w <= check_bits; w++) begin
            for (int v = 0; v < (1 << check_bits); v++) begin
                if ($countones(v) == w && filled < MaxCols) begin
                    cols[filled] = CheckW'(v);
                    filled++;
                end
            end
        end
        return cols;
    endfunction

    // Maps each syndrome to the lowest data bit whose column equals it.
    function automatic lookup_table_t build_lookup(input col_table_t cols,
                                                   input int data_bits);
        lookup_table_t tab;
        tab = '0;
        for (int s = 1; s < SyndCount; s++) begin
            for (int j = MaxCols - 1; j >= 0; j--) begin
                if (j < data_bits && cols[j] == CheckW'(s)) begin
                    tab[s].hit = 1'b1;
                    tab[s].idx = IdxW'(j);
                end
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ----- design/systematic_hamming_sec_codec.sv -----
// ----------------------------------------------------------------------------
// systematic_hamming_sec_codec
// Three-stage pipelined systematic Hamming SEC encoder and decoder.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_ stream: s_tuser carries the mode (0 encode,
// 1 decode), s_tdata the data word and the received check bits. Each item
// yields one result item on the m_ stream with the computed check bits,
// the syndrome, the corrected data, the error position and the status.
// The block takes one item per cycle while m_tready is high. An accepted
// item passes three register stages before it shows on m_tvalid: an input
// register, then a check-bit XOR tree with the syndrome and a syndrome
// table lookup with the bit flip, each followed by a register.
// Every stage holds its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles collapse and a stall of the
// receiver backs up the pipeline without losing or repeating an item.
// Up to three items are held while m_tready is low.
// Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module systematic_hamming_sec_codec
    import hsc_pkg::*;
#(
    parameter int DATA_BITS  = 32,
    parameter int CHECK_BITS = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: data_word[31:0], check_word[37:32], zero fill.
    input  wire logic [39:0] s_tdata,
    // Fields from bit 0: mode[0].
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: check_bits[5:0], syndrome[11:6],
    // corrected_data[43:12], error_position[48:44], status[50:49], zero fill.
    output logic [55:0]      m_tdata
);

    localparam col_table_t    Columns   = build_columns(CHECK_BITS);
    localparam lookup_table_t Lookup    = build_lookup(Columns, DATA_BITS);
    localparam logic [CheckW-1:0] CheckMask = CheckW'((1 << CHECK_BITS) - 1);

    // Stage 1: input register.
    logic              v1_reg;
    logic              mode1_reg;
    logic [DataW-1:0]  data1_reg;
    logic [CheckW-1:0] recv1_reg;

    // Stage 2: check bits and syndrome.
    logic              v2_reg;
    logic [DataW-1:0]  data2_reg;
    logic [CheckW-1:0] check2_reg;
    logic [CheckW-1:0] synd2_reg;
    logic [CheckW-1:0] check2_next;
    logic [CheckW-1:0] synd2_next;

    // Stage 3: output register.
    logic               v3_reg;
    logic [CheckW-1:0]  check3_reg;
    logic [CheckW-1:0]  synd3_reg;
    logic [DataW-1:0]   fixed3_reg;
    logic [PosW-1:0]    pos3_reg;
    logic [StatusW-1:0] status3_reg;
    logic [DataW-1:0]   fixed3_next;
    logic [PosW-1:0]    pos3_next;
    logic [StatusW-1:0] status3_next;
    lookup_entry_t      entry;

    logic ready1;
    logic ready2;
    logic ready3;

    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;

    always_comb begin
        check2_next = '0;
        for (int j = 0; j < DataW; j++) begin
            if (j < DATA_BITS && data1_reg[j]) begin
                check2_next = check2_next ^ Columns[j];
            end
        end
        check2_next = check2_next & CheckMask;
        synd2_next  = mode1_reg ? ((recv1_reg ^ check2_next) & CheckMask) : '0;
    end

    always_comb begin
        entry        = Lookup[synd2_reg];
        fixed3_next  = data2_reg;
        pos3_next    = '0;
        status3_next = StatusNone;
        if (synd2_reg != '0) begin
            if (entry.hit) begin
                status3_next = StatusCorrected;
                pos3_next    = entry.idx[PosW-1:0];
                if (!entry.idx[IdxW-1]) begin
                    fixed3_next = data2_reg ^ (DataW'(1) << entry.idx[PosW-1:0]);
                end
            end else begin
                status3_next = StatusUnmatched;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && s_tvalid) begin
            mode1_reg <= s_tuser[0];
            data1_reg <= s_tdata[31:0];
            recv1_reg <= s_tdata[37:32];
        end
        if (ready2 && v1_reg) begin
            data2_reg  <= data1_reg;
            check2_reg <= check2_next;
            synd2_reg  <= synd2_next;
        end
        if (ready3 && v2_reg) begin
            check3_reg  <= check2_reg;
            synd3_reg   <= synd2_reg;
            fixed3_reg  <= fixed3_next;
            pos3_reg    <= pos3_next;
            status3_reg <= status3_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {5'd0, status3_reg, pos3_reg, fixed3_reg, synd3_reg, check3_reg};

endmodule

`default_nettype wire
